### hdl/cpc_pkg.sv
// Package for the Cyrillic code page to UTF-8 unit: types, code page codes, mapping tables.
`default_nettype none
package cpc_pkg;

    localparam int unsigned SEQ_MAX = 3;

    typedef enum logic [1:0] {
        CP_WIN1251  = 2'd0,
        CP_ISO88595 = 2'd1,
        CP_KOI8R    = 2'd2,
        CP_LATIN1   = 2'd3
    } t_codepage;

    // One encoded character: bytes[0] goes out first, count is 1 to 3.
    typedef struct packed {
        logic [SEQ_MAX-1:0][7:0] bytes;
        logic [1:0]              count;
    } t_utf8_seq;

    localparam logic [15:0] WIN1251_HI [64] = '{
        16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
        16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'hFFFF, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
        16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
        16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
        16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
    };

    localparam logic [15:0] KOI8R_HI [128] = '{
        16'h2500, 16'h2502, 16'h250C, 16'h2510, 16'h2514, 16'h2518, 16'h251C, 16'h2524,
        16'h252C, 16'h2534, 16'h253C, 16'h2580, 16'h2584, 16'h2588, 16'h258C, 16'h2590,
        16'h2591, 16'h2592, 16'h2593, 16'h2320, 16'h25A0, 16'h2219, 16'h221A, 16'h2248,
        16'h2264, 16'h2265, 16'h00A0, 16'h2321, 16'h00B0, 16'h00B2, 16'h00B7, 16'h00F7,
        16'h2550, 16'h2551, 16'h2552, 16'h0451, 16'h2553, 16'h2554, 16'h2555, 16'h2556,
        16'h2557, 16'h2558, 16'h2559, 16'h255A, 16'h255B, 16'h255C, 16'h255D, 16'h255E,
        16'h255F, 16'h2560, 16'h2561, 16'h0401, 16'h2562, 16'h2563, 16'h2564, 16'h2565,
        16'h2566, 16'h2567, 16'h2568, 16'h2569, 16'h256A, 16'h256B, 16'h256C, 16'h00A9,
        16'h044E, 16'h0430, 16'h0431, 16'h0446, 16'h0434, 16'h0435, 16'h0444, 16'h0433,
        16'h0445, 16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E,
        16'h043F, 16'h044F, 16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0436, 16'h0432,
        16'h044C, 16'h044B, 16'h0437, 16'h0448, 16'h044D, 16'h0449, 16'h0447, 16'h044A,
        16'h042E, 16'h0410, 16'h0411, 16'h0426, 16'h0414, 16'h0415, 16'h0424, 16'h0413,
        16'h0425, 16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E,
        16'h041F, 16'h042F, 16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0416, 16'h0412,
        16'h042C, 16'h042B, 16'h0417, 16'h0428, 16'h042D, 16'h0429, 16'h0427, 16'h042A
    };

endpackage
`default_nettype wire

### hdl/cyrillic_codepage_to_utf8_unit.sv
// Top level of the Cyrillic code page to UTF-8 unit.
`default_nettype none
// Converts one byte of windows-1251, ISO-8859-5 or KOI8-R text (chosen by
// i_cfg_wdata: 0, 1, 2; 3 reads the byte as ISO-8859-1) into its UTF-8 sequence
// of one to three beats on the output stream, tlast on the final beat. The
// input byte is registered, then mapped and encoded combinationally into the
// result register once that register is empty or its final beat is leaving.
// The output stream carries one byte per cycle while the output is ready,
// so a character occupies as many beats as its UTF-8 length; the input register
// can take the next byte while the previous character is still being sent, and
// with the output always ready there are no gaps between characters.
// Write the code page only while the unit is idle.
module cyrillic_codepage_to_utf8_unit
    import cpc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wen,
    input  wire logic [1:0] i_cfg_wdata,      // codepage_select
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // src_byte[7:0]
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // utf8_byte[7:0]
    output logic            o_m_axis_tlast    // last_byte
);

    t_codepage  r_codepage;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       can_load;
    logic       load;
    t_utf8_seq  seq;

    assign load            = r_in_valid && can_load;
    assign o_s_axis_tready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codepage <= CP_WIN1251;
        end else if (i_cfg_wen) begin
            r_codepage <= t_codepage'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    cpc_map u_map (
        .i_codepage (r_codepage),
        .i_byte     (r_in_byte),
        .o_seq      (seq)
    );

    cpc_ser u_ser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_seq           (seq),
        .o_can_load      (can_load),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

`ifndef SYNTH
    // A waiting byte moves into the result register as the final beat leaves.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast && r_in_valid)
        |=> o_m_axis_tvalid)
        else $error("output bubble with a byte pending");

    // Non-final beats are lead or continuation bytes.
    a_mid_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast)
        |-> (o_m_axis_tdata[7:6] == 2'b11 || o_m_axis_tdata[7:6] == 2'b10))
        else $error("bad non-final UTF-8 byte");

    // A sequence never ends on a lead byte.
    a_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tdata[7:6] != 2'b11))
        else $error("UTF-8 sequence ends on a lead byte");
`endif

endmodule
`default_nettype wire

### hdl/cpc_map.sv
// Maps a code page byte to its code point and encodes that as a UTF-8 sequence.
`default_nettype none
module cpc_map
    import cpc_pkg::*;
(
    input  wire t_codepage  i_codepage,
    input  wire logic [7:0] i_byte,
    output t_utf8_seq       o_seq
);

    logic [15:0] cp;

    always_comb begin
        cp = {8'h00, i_byte};
        case (i_codepage)
            CP_WIN1251: begin
                if (i_byte[7:6] == 2'b11) begin
                    cp = 16'h0410 + {10'd0, i_byte[5:0]};
                end else if (i_byte[7]) begin
                    cp = WIN1251_HI[i_byte[5:0]];
                end
            end
            CP_ISO88595: begin
                if (i_byte == 8'hAD) begin
                    cp = 16'h00AD;
                end else if (i_byte == 8'hF0) begin
                    cp = 16'h2116;
                end else if (i_byte == 8'hFD) begin
                    cp = 16'h00A7;
                end else if (i_byte >= 8'hA1) begin
                    cp = 16'h0401 + {8'h00, i_byte} - 16'h00A1;
                end
            end
            CP_KOI8R: begin
                if (i_byte[7]) begin
                    cp = KOI8R_HI[i_byte[6:0]];
                end
            end
            default: begin
                cp = {8'h00, i_byte};
            end
        endcase
    end

    always_comb begin
        o_seq = '0;
        if (cp < 16'h0080) begin
            o_seq.count    = 2'd1;
            o_seq.bytes[0] = cp[7:0];
        end else if (cp < 16'h0800) begin
            o_seq.count    = 2'd2;
            o_seq.bytes[0] = {3'b110, cp[10:6]};
            o_seq.bytes[1] = {2'b10, cp[5:0]};
        end else begin
            o_seq.count    = 2'd3;
            o_seq.bytes[0] = {4'b1110, cp[15:12]};
            o_seq.bytes[1] = {2'b10, cp[11:6]};
            o_seq.bytes[2] = {2'b10, cp[5:0]};
        end
    end

endmodule
`default_nettype wire

### hdl/cpc_ser.sv
// Result register: holds one encoded character and shifts its bytes out one beat at a time.
`default_nettype none
module cpc_ser
    import cpc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_utf8_seq  i_seq,
    output logic            o_can_load,
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // utf8_byte[7:0]
    output logic            o_m_axis_tlast    // last_byte
);

    logic [SEQ_MAX-1:0][7:0] r_bytes;
    logic [1:0]              r_cnt;
    logic                    take;

    assign take            = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = r_bytes[0];
    assign o_m_axis_tlast  = (r_cnt == 2'd1);
    // Empty, or the final beat leaves this cycle.
    assign o_can_load      = (r_cnt == 2'd0) || (o_m_axis_tlast && i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_seq.count;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_seq.bytes;
        end else if (take) begin
            r_bytes <= {8'h00, r_bytes[SEQ_MAX-1:1]};
        end
    end

endmodule
`default_nettype wire
